@@ rtl/core/rau_pkg.sv @@
// Shared types, constants and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    // Operand width and derived datapath widths
    localparam int RAU_W  = 16;
    localparam int RAU_PW = 2 * RAU_W;
    localparam int RAU_CW = $clog2(RAU_PW + 1);
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 31;

    // Opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_GT  = 3'd4;
    localparam logic [2:0] OP_LT  = 3'd5;
    localparam logic [2:0] OP_EQ  = 3'd6;
    localparam logic [2:0] OP_NE  = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [2:0]              opcode;
        logic signed [RAU_W-1:0] num_a;
        logic signed [RAU_W-1:0] den_a;
        logic signed [RAU_W-1:0] num_b;
        logic signed [RAU_W-1:0] den_b;
    } t_in;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_num;
        logic [DEN_W-1:0]        result_den;
        logic                    compare_true;
        logic [1:0]              status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic mul2;
        logic comb;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic div_store;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic is_cmp;
        logic num_zero;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/core/rau_dp.sv @@
// Datapath: shared multiplier, signed combine, binary gcd and two serial dividers.
`default_nettype none
module rau_dp import rau_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_in   i_in_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    output t_out  o_out_data
);

    function automatic logic [RAU_W-1:0] mag_of(input logic [RAU_W-1:0] x);
        return x[RAU_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Operand registers
    logic [2:0]       r_op;
    logic [RAU_W-1:0] r_na, r_da, r_nb, r_db;
    logic             r_sa, r_sb, r_bad;

    // Products, combined numerator, gcd and divider state
    logic [RAU_PW-1:0] r_p0, r_p1, r_den;
    logic [RAU_PW-1:0] r_u, r_v, r_a, r_d;
    logic              r_neg, r_num_zero;
    logic [RAU_PW-1:0] r_qa, r_qd;
    logic [RAU_PW:0]   r_ra, r_rd;
    logic [RAU_CW-1:0] r_cnt;

    // Pending result and output register
    logic signed [NUM_W-1:0] r_res_num;
    logic [DEN_W-1:0]        r_res_den;
    logic                    r_res_cmp;
    logic [1:0]              r_res_status;
    t_out                    r_out;
    logic                    r_out_valid;

    logic              is_cmp;
    logic              zden, divz;
    logic [RAU_W-1:0]  mx, my;
    logic [RAU_PW-1:0] prod;
    logic              pb_neg;
    logic [RAU_PW-1:0] c_mag;
    logic              c_neg, c_eq, c_res;
    logic [RAU_PW:0]   ra_sh, rd_sh, dvs;
    logic              ge_a, ge_d;
    logic [RAU_PW+NUM_W-1:0] qa_wide;
    logic [RAU_PW+DEN_W-1:0] qd_wide;
    logic [NUM_W-1:0]        qa_trim;

    assign is_cmp = (r_op == OP_GT) || (r_op == OP_LT) || (r_op == OP_EQ) || (r_op == OP_NE);
    assign zden   = (i_in_data.den_a == '0) || (i_in_data.den_b == '0);
    assign divz   = (i_in_data.opcode == OP_DIV) && (i_in_data.num_b == '0);

    // Shared multiplier operand selection
    always_comb begin
        mx = r_na;
        my = (r_op == OP_MUL) ? r_nb : r_db;
        if (i_cmd.mul1) begin
            mx = r_nb;
            my = r_da;
        end else if (i_cmd.mul2) begin
            mx = r_da;
            my = (r_op == OP_DIV) ? r_nb : r_db;
        end
    end
    assign prod = RAU_PW'(mx) * RAU_PW'(my);

    // Signed combine of the cross products
    always_comb begin
        pb_neg = (r_op == OP_ADD) ? r_sb : ~r_sb;
        c_mag  = r_p0;
        c_neg  = r_sa ^ r_sb;
        if ((r_op != OP_MUL) && (r_op != OP_DIV)) begin
            if (r_sa == pb_neg) begin
                c_mag = r_p0 + r_p1;
                c_neg = r_sa;
            end else if (r_p0 >= r_p1) begin
                c_mag = r_p0 - r_p1;
                c_neg = r_sa;
            end else begin
                c_mag = r_p1 - r_p0;
                c_neg = pb_neg;
            end
        end
        c_eq = (c_mag == '0);
        case (r_op)
            OP_GT:   c_res = !c_eq && !c_neg;
            OP_LT:   c_res = !c_eq && c_neg;
            OP_EQ:   c_res = c_eq;
            default: c_res = !c_eq;
        endcase
    end

    // Restoring division step for both quotients
    assign dvs   = {1'b0, r_u};
    assign ra_sh = {r_ra[RAU_PW-1:0], r_qa[RAU_PW-1]};
    assign rd_sh = {r_rd[RAU_PW-1:0], r_qd[RAU_PW-1]};
    assign ge_a  = ra_sh >= dvs;
    assign ge_d  = rd_sh >= dvs;

    assign qa_wide = {{NUM_W{1'b0}}, r_qa};
    assign qd_wide = {{DEN_W{1'b0}}, r_qd};
    assign qa_trim = qa_wide[NUM_W-1:0];

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_in_data.opcode;
            r_na         <= mag_of(i_in_data.num_a);
            r_da         <= mag_of(i_in_data.den_a);
            r_nb         <= mag_of(i_in_data.num_b);
            r_db         <= mag_of(i_in_data.den_b);
            r_sa         <= i_in_data.num_a[RAU_W-1] ^ i_in_data.den_a[RAU_W-1];
            r_sb         <= i_in_data.num_b[RAU_W-1] ^ i_in_data.den_b[RAU_W-1];
            r_bad        <= zden || divz;
            r_res_status <= zden ? ST_ZDEN : (divz ? ST_DIVZ : ST_OK);
            r_res_num    <= '0;
            r_res_den    <= DEN_W'(1);
            r_res_cmp    <= 1'b0;
        end
        if (i_cmd.mul0) r_p0  <= prod;
        if (i_cmd.mul1) r_p1  <= prod;
        if (i_cmd.mul2) r_den <= prod;
        if (i_cmd.comb) begin
            r_neg      <= c_neg;
            r_num_zero <= c_eq;
            r_a        <= c_mag;
            r_u        <= c_mag;
            r_d        <= r_den;
            r_v        <= r_den;
            if (is_cmp) r_res_cmp <= c_res;
        end
        // Binary gcd: common factors of two come off the operands as well
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_a <= r_a >> 1;
                r_d <= r_d >> 1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        if (i_cmd.div_init) begin
            r_qa  <= r_a;
            r_qd  <= r_d;
            r_ra  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_ra  <= ge_a ? (ra_sh - dvs) : ra_sh;
            r_rd  <= ge_d ? (rd_sh - dvs) : rd_sh;
            r_qa  <= {r_qa[RAU_PW-2:0], ge_a};
            r_qd  <= {r_qd[RAU_PW-2:0], ge_d};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.div_store) begin
            r_res_num <= r_neg ? (~qa_trim + 1'b1) : qa_trim;
            r_res_den <= qd_wide[DEN_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out.result_num   <= r_res_num;
            r_out.result_den   <= r_res_den;
            r_out.compare_true <= r_res_cmp;
            r_out.status       <= r_res_status;
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.bad      = r_bad;
    assign o_stat.is_cmp   = is_cmp;
    assign o_stat.num_zero = r_num_zero;
    assign o_stat.gcd_done = (r_u == r_v);
    assign o_stat.div_done = (r_cnt == RAU_CW'(RAU_PW));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ rtl/core/rau_ctrl.sv @@
// Controller: sequences multiply, combine, gcd and divide steps for one beat.
`default_nettype none
module rau_ctrl import rau_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul0 = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = i_stat.is_cmp ? S_DONE : S_GCD;
            end
            S_GCD: begin
                if (i_stat.num_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
//
//  channel | direction | handshake                 | beat
//  input   | in        | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  output  | out       | o_out_valid / i_out_stall | o_out_data (t_out)
//
// One beat at a time. Operand error beats skip the multiply, gcd and divide, comparisons end
// after the combine step and zero arithmetic results skip the gcd and divide; other arithmetic
// beats run the binary gcd on the 32-bit cross products and then the serial divide. Reset
// is synchronous and clears the controller and the output valid. A stalled output holds its
// beat and adds its stall to the current beat; the next input is taken as soon as the
// finished result sits in the output register.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
